FILE: rtl/vpbd_pkg.sv
// Shared types, mode codes and palette for the VGA pixel byte decoder.
package vpbd_pkg;

    localparam logic [2:0] MODE_TEXT     = 3'd0;
    localparam logic [2:0] MODE_PLANAR   = 3'd1;
    localparam logic [2:0] MODE_SHIFT256 = 3'd2;
    localparam logic [2:0] MODE_MONO     = 3'd3;
    localparam logic [2:0] MODE_2BPP     = 3'd4;

    localparam logic [23:0] MONO_ON_COLOR = 24'h8080ff;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] plane0_byte;
        logic [7:0] plane1_byte;
        logic [7:0] plane2_byte;
        logic [7:0] plane3_byte;
    } item_t;

    typedef struct packed {
        logic [23:0] color;
        logic [23:0] back_color;
        logic [7:0]  char_code;
        logic        last;
    } pix_t;

    function automatic logic [23:0] palette16(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:  c = 24'h000000;
            4'd1:  c = 24'h800000;
            4'd2:  c = 24'h008000;
            4'd3:  c = 24'h808000;
            4'd4:  c = 24'h000080;
            4'd5:  c = 24'h800080;
            4'd6:  c = 24'h008080;
            4'd7:  c = 24'hc0c0c0;
            4'd8:  c = 24'h808080;
            4'd9:  c = 24'hff0000;
            4'd10: c = 24'h00ff00;
            4'd11: c = 24'hffff00;
            4'd12: c = 24'h0000ff;
            4'd13: c = 24'hff00ff;
            4'd14: c = 24'h00ffff;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    function automatic logic mode_valid(input logic [2:0] mode);
        return (mode <= MODE_2BPP);
    endfunction

endpackage

FILE: rtl/vpbd_cfg.sv
// Configuration register file holding the pixel mode.
module vpbd_cfg
    import vpbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [2:0]  pixel_mode
);

    logic [2:0] pixel_mode_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg <= MODE_PLANAR;
        end
        else if (wr_en)
        begin
            pixel_mode_reg <= pwdata[2:0];
        end
    end

    assign prdata     = paddr[2] ? 32'd0 : {29'd0, pixel_mode_reg};
    assign pixel_mode = pixel_mode_reg;

endmodule

FILE: rtl/vpbd_pixel_sel.sv
// Per-pixel decode: picks pixel k of a fetch; every mode but mono maps it via the palette.
module vpbd_pixel_sel
    import vpbd_pkg::*;
(
    input  item_t      item,
    input  logic [2:0] k,
    output pix_t       pix
);

    logic [2:0] bit_sel;
    logic [2:0] hi_sel;
    logic [2:0] lo_sel;
    logic [3:0] planar_idx;

    assign bit_sel = ~k;
    assign hi_sel  = {~k[1:0], 1'b1};
    assign lo_sel  = {~k[1:0], 1'b0};

    assign planar_idx = {item.plane3_byte[bit_sel], item.plane2_byte[bit_sel],
                         item.plane1_byte[bit_sel], item.plane0_byte[bit_sel]};

    always_comb
    begin
        pix = '0;
        unique case (item.mode)
            MODE_TEXT:
            begin
                pix.color      = palette16(item.plane1_byte[3:0]);
                pix.back_color = palette16(item.plane1_byte[7:4]);
                pix.char_code  = item.plane0_byte;
                pix.last       = 1'b1;
            end
            MODE_PLANAR:
            begin
                pix.color = palette16(planar_idx);
                pix.last  = (k == 3'd7);
            end
            MODE_SHIFT256:
            begin
                pix.color = palette16(item.plane0_byte[3:0]);
                pix.last  = 1'b1;
            end
            MODE_MONO:
            begin
                pix.color = item.plane0_byte[bit_sel] ? MONO_ON_COLOR : 24'd0;
                pix.last  = (k == 3'd7);
            end
            MODE_2BPP:
            begin
                pix.color = palette16({2'b00, item.plane0_byte[hi_sel],
                                       item.plane0_byte[lo_sel]});
                pix.last  = (k == 3'd3);
            end
            default:
            begin
                pix = '0;
            end
        endcase
    end

endmodule

FILE: rtl/vga_pixel_byte_decoder_unit.sv
// Top level of the VGA pixel byte decoder: fetch register, pixel serializer and result register.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one display fetch of four plane bytes.
//   Output channel (out_valid/out_stall) carries one pixel per request: color,
//   back_color, char_code and last, which marks the final pixel of a fetch.
//   The APB port holds pixel_mode at address 0; write it only while the block is idle.
//   A fetch is held in the fetch register and decoded one pixel per cycle into the
//   result register while the receiver does not stall. The first pixel goes from the
//   fetch register into the result register when the result register can advance. A fetch
//   yields 8 pixels in planar and mono mode, 4 in 2bpp mode and 1 in text and shift256 mode.
//   The next fetch is taken in the cycle its predecessor's last pixel advances, so
//   fetches follow back to back. Fetches in unused modes are taken and dropped.
//   When the receiver stalls, the result register and the fetch register hold and
//   in_stall rises once the fetch register is occupied.
//   Reset clears both valid flags and sets pixel_mode to planar 16-color.
module vga_pixel_byte_decoder_unit
    import vpbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  plane0_byte,
    input  logic [7:0]  plane1_byte,
    input  logic [7:0]  plane2_byte,
    input  logic [7:0]  plane3_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] color,
    output logic [23:0] back_color,
    output logic [7:0]  char_code,
    output logic        last
);

    logic [2:0] pixel_mode;
    item_t      item_reg;
    logic       a_valid_reg;
    logic [2:0] k_reg;
    pix_t       pix;
    pix_t       out_reg;
    logic       out_valid_reg;
    logic       out_adv;
    logic       a_adv;
    logic       a_done;
    logic       in_accept;

    vpbd_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pixel_mode (pixel_mode)
    );

    vpbd_pixel_sel u_sel (
        .item (item_reg),
        .k    (k_reg),
        .pix  (pix)
    );

    assign out_adv   = !out_valid_reg || !out_stall;
    assign a_adv     = a_valid_reg && out_adv;
    assign a_done    = a_adv && pix.last;
    assign in_stall  = a_valid_reg && !a_done;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            k_reg       <= 3'd0;
        end
        else if (in_accept)
        begin
            a_valid_reg <= mode_valid(pixel_mode);
            k_reg       <= 3'd0;
        end
        else if (a_done)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            k_reg <= k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.mode        <= pixel_mode;
            item_reg.plane0_byte <= plane0_byte;
            item_reg.plane1_byte <= plane1_byte;
            item_reg.plane2_byte <= plane2_byte;
            item_reg.plane3_byte <= plane3_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            out_reg <= pix;
        end
    end

    assign out_valid  = out_valid_reg;
    assign color      = out_reg.color;
    assign back_color = out_reg.back_color;
    assign char_code  = out_reg.char_code;
    assign last       = out_reg.last;

`ifndef SYNTHESIS
    a_load_valid_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && mode_valid(pixel_mode) |=> a_valid_reg && k_reg == 3'd0)
        else $error("valid-mode fetch not loaded");

    a_drop_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !mode_valid(pixel_mode) |=> !a_valid_reg)
        else $error("unused-mode fetch not dropped");

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && item_reg.mode == MODE_2BPP |-> k_reg <= 3'd3)
        else $error("pixel index past end of 2bpp fetch");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        a_done && !in_valid |=> !a_valid_reg)
        else $error("fetch register not freed after last pixel");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the VGA pixel byte decoder: directed and random fetches.
`timescale 1ns / 1ps

module testbench;
    import vpbd_pkg::*;

    localparam logic [2:0] ADDR_PIXEL_MODE = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;
    localparam logic [2:0] MODE_RSVD5      = 3'd5;
    localparam logic [2:0] MODE_RSVD6      = 3'd6;
    localparam logic [2:0] MODE_RSVD7      = 3'd7;
    localparam int         SETTLE_CYCLES   = 16;
    localparam int         RANDOM_FETCHES  = 300;
    localparam int         QUIET_FETCHES   = 260;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  plane0_byte = '0;
    logic [7:0]  plane1_byte = '0;
    logic [7:0]  plane2_byte = '0;
    logic [7:0]  plane3_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [23:0] color;
    logic [23:0] back_color;
    logic [7:0]  char_code;
    logic        last;

    logic [2:0] mode_shadow = MODE_PLANAR;
    pix_t       pixel_q[$];
    int         mismatches = 0;
    int         stall_left = 0;
    bit         gap_on = 1'b1;
    bit         stall_on = 1'b1;

    vga_pixel_byte_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .plane0_byte (plane0_byte),
        .plane1_byte (plane1_byte),
        .plane2_byte (plane2_byte),
        .plane3_byte (plane3_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .color       (color),
        .back_color  (back_color),
        .char_code   (char_code),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [23:0] vga_color(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'h0: c = 24'h000000;
            4'h1: c = 24'h800000;
            4'h2: c = 24'h008000;
            4'h3: c = 24'h808000;
            4'h4: c = 24'h000080;
            4'h5: c = 24'h800080;
            4'h6: c = 24'h008080;
            4'h7: c = 24'hc0c0c0;
            4'h8: c = 24'h808080;
            4'h9: c = 24'hff0000;
            4'ha: c = 24'h00ff00;
            4'hb: c = 24'hffff00;
            4'hc: c = 24'h0000ff;
            4'hd: c = 24'hff00ff;
            4'he: c = 24'h00ffff;
            default: c = 24'hffffff;
        endcase
        return c;
    endfunction

    task automatic decode_fetch(input logic [2:0] mode, input logic [7:0] p0,
                                input logic [7:0] p1, input logic [7:0] p2,
                                input logic [7:0] p3);
        pix_t       px;
        logic [3:0] idx;
        px.color      = '0;
        px.back_color = '0;
        px.char_code  = '0;
        px.last       = 1'b1;
        case (mode)
            MODE_TEXT:
            begin
                px.color      = vga_color(p1[3:0]);
                px.back_color = vga_color(p1[7:4]);
                px.char_code  = p0;
                pixel_q.push_back(px);
            end
            MODE_PLANAR:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    idx      = {p3[7-k], p2[7-k], p1[7-k], p0[7-k]};
                    px.color = vga_color(idx);
                    px.last  = (k == 7);
                    pixel_q.push_back(px);
                end
            end
            MODE_SHIFT256:
            begin
                px.color = vga_color(p0[3:0]);
                pixel_q.push_back(px);
            end
            MODE_MONO:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    px.color = p0[7-k] ? MONO_ON_COLOR : 24'h000000;
                    px.last  = (k == 7);
                    pixel_q.push_back(px);
                end
            end
            MODE_2BPP:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    idx      = {2'b00, p0[7-2*k -: 2]};
                    px.color = vga_color(idx);
                    px.last  = (k == 3);
                    pixel_q.push_back(px);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_fetch(input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input logic [7:0] p3);
        @(negedge clk);
        if (gap_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        plane0_byte = p0;
        plane1_byte = p1;
        plane2_byte = p2;
        plane3_byte = p3;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        decode_fetch(mode_shadow, p0, p1, p2, p3);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pixel_q.size() != 0) @(negedge clk);
    endtask

    task automatic set_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_PIXEL_MODE)
            mode_shadow = data[2:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_PIXEL_MODE;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[2:0] !== mode_shadow)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mode readback: expected %0d got %0d", mode_shadow, prdata[2:0]);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  = 1'b1;
            stall_left = stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin : check_pixels
        pix_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel: color %h back %h char %h last %b",
                             color, back_color, char_code, last);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (color !== want.color || back_color !== want.back_color ||
                    char_code !== want.char_code || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h/%h/%h/%b got %h/%h/%h/%b",
                                 want.color, want.back_color, want.char_code, want.last,
                                 color, back_color, char_code, last);
                end
            end
        end
    end

    task automatic test_planar_reset();
        send_fetch(8'h00, 8'h00, 8'h00, 8'h00);
        send_fetch(8'hff, 8'hff, 8'hff, 8'hff);
        send_fetch(8'hff, 8'h00, 8'h00, 8'h00);
        send_fetch(8'h00, 8'hff, 8'h00, 8'h00);
        send_fetch(8'h00, 8'h00, 8'hff, 8'h00);
        send_fetch(8'ha5, 8'h5a, 8'h3c, 8'hc3);
    endtask

    task automatic test_text();
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_TEXT});
        send_fetch(8'h00, 8'h00, 8'hff, 8'hff);
        send_fetch(8'hff, 8'hff, 8'h00, 8'h00);
        send_fetch(8'h41, 8'h0f, 8'h12, 8'h34);
        send_fetch(8'h7e, 8'hf0, 8'h56, 8'h78);
        send_fetch(8'h80, 8'h9e, 8'h00, 8'h00);
    endtask

    task automatic test_shift256();
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_SHIFT256});
        send_fetch(8'h00, 8'hff, 8'hff, 8'hff);
        send_fetch(8'hff, 8'h00, 8'h00, 8'h00);
        send_fetch(8'hf7, 8'h12, 8'h34, 8'h56);
    endtask

    task automatic test_mono();
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_MONO});
        send_fetch(8'h00, 8'hff, 8'hff, 8'hff);
        send_fetch(8'hff, 8'h00, 8'h00, 8'h00);
        send_fetch(8'ha5, 8'h5a, 8'h00, 8'hff);
    endtask

    task automatic test_2bpp();
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_2BPP});
        send_fetch(8'h1b, 8'hff, 8'hff, 8'hff);
        send_fetch(8'he4, 8'h00, 8'h00, 8'h00);
        send_fetch(8'hff, 8'h55, 8'haa, 8'h0f);
    endtask

    task automatic test_register_corners();
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_RSVD5});
        send_fetch(8'hff, 8'hff, 8'hff, 8'hff);
        set_reg(ADDR_PIXEL_MODE, {29'd0, MODE_RSVD6});
        send_fetch(8'h00, 8'h00, 8'h00, 8'h00);
        set_reg(ADDR_PIXEL_MODE, {29'h1fff_ffff, MODE_RSVD7});
        send_fetch(8'h5a, 8'ha5, 8'h3c, 8'hc3);
        set_reg(ADDR_PIXEL_MODE, {29'h1fff_fff1, MODE_TEXT} ^ 32'h0000_0004);
        set_reg(ADDR_UNMAPPED, {29'd0, MODE_MONO});
        send_fetch(8'h96, 8'h69, 8'h00, 8'h00);
    endtask

    task automatic test_random();
        int          counted;
        int          phase_len;
        int          r;
        bit          paused;
        logic [2:0]  mode;
        logic [31:0] noise;
        counted = 0;
        paused  = 1'b0;
        while (counted < RANDOM_FETCHES)
        begin
            r     = $urandom_range(0, 15);
            mode  = (r < 13) ? 3'(r % 5) : 3'(r - 8);
            noise = $urandom;
            if ($urandom_range(0, 3) == 0)
                set_reg(ADDR_UNMAPPED, $urandom);
            set_reg(ADDR_PIXEL_MODE, {noise[31:3], mode});
            gap_on    = (counted < QUIET_FETCHES) && ($urandom_range(0, 3) != 0);
            stall_on  = (counted < QUIET_FETCHES) && ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(4, 30);
            for (int i = 0; i < phase_len; i++)
            begin
                send_fetch($urandom, $urandom, $urandom, $urandom);
                counted++;
                if (!paused && counted >= RANDOM_FETCHES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end
        gap_on   = 1'b0;
        stall_on = 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("FAIL vga_pixel_byte_decoder_unit");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_planar_reset();
        test_text();
        test_shift256();
        test_mono();
        test_2bpp();
        test_register_corners();
        test_random();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pixel_q.size() == 0)
            $display("PASS vga_pixel_byte_decoder_unit");
        else
            $display("FAIL vga_pixel_byte_decoder_unit");
        $finish;
    end

endmodule
